>>> sv/bavg_pkg.sv
`timescale 1ns / 1ps

package bavg_pkg;

	// Build defaults
	localparam int OUT_WIDTH_DEF = 256;

	// Scale register
	localparam int SCALE_W = 10;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd200;
	localparam logic [SCALE_W-1:0] SCALE_MIN = 10'd100;
	localparam int SCALE_MAX = 1023;

	// Field widths
	localparam int PIX_W = 16;
	localparam int ROW_W = 10;
	localparam int COL_OUT_W = 8;
	localparam int OROW_W = 8;
	localparam int SRC_COL_W = 16;
	localparam logic [SRC_COL_W-1:0] SRC_COL_SAT = '1;

	// Channel sums, one lane per colour
	localparam int CHAN_W = 16;
	localparam int CHAN_N = 3;
	localparam int CH_R = 2;
	localparam int CH_G = 1;
	localparam int CH_B = 0;
	localparam int ENTRY_W = CHAN_N * CHAN_W;

	// Last scanline of an output row stays below 256 * 1023 / 100
	localparam int LAST_W = 12;
	// Pixels in one column group never exceed eleven
	localparam int PCNT_W = 4;
	// Group pixels times rows stays below 4096
	localparam int DVS_W = 12;
	// Narrowest product word of the boundary unit
	localparam int PROD_MIN_W = 18;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef chan_t [CHAN_N-1:0] chan_vec_t;

	typedef enum logic {
		KIND_FRAME = 1'b0,
		KIND_PIXEL = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BOUNDS,
		ST_ADD,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		kind_t             kind;
		logic [PIX_W-1:0]  pixel_value;
		logic [ROW_W-1:0]  scan_row;
		logic              line_end;
	} item_t;

	typedef struct packed {
		logic [PIX_W-1:0]     out_pixel;
		logic [COL_OUT_W-1:0] out_column;
		logic [OROW_W-1:0]    out_row;
		logic                 last_in_row;
	} result_t;

endpackage

>>> sv/bavg_ram.sv
`timescale 1ns / 1ps

module bavg_ram import bavg_pkg::*; #(
	parameter int WIDTH = ENTRY_W,
	parameter int DEPTH = OUT_WIDTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/bavg_bounds.sv
`timescale 1ns / 1ps

module bavg_bounds import bavg_pkg::*; #(
	parameter int OUT_WIDTH = OUT_WIDTH_DEF,
	localparam int GI_W = $clog2(OUT_WIDTH + 1),
	localparam int END_W = $clog2(OUT_WIDTH * SCALE_MAX / 100 + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [GI_W-1:0]    grp,
	input  logic [OROW_W-1:0]  orow,
	input  logic [SCALE_W-1:0] scale,
	output logic               done,
	output logic [END_W-1:0]   start_col,
	output logic [END_W-1:0]   end_col,
	output logic [LAST_W-1:0]  last_line
);

	localparam int PROD_W = $clog2(OUT_WIDTH * SCALE_MAX + 1);
	localparam int N_W = (PROD_W > PROD_MIN_W) ? PROD_W : PROD_MIN_W;
	localparam int Q_W = N_W - 6;
	localparam int M_W = N_W + 1;
	localparam int RECIP_SH = N_W + 7;
	localparam logic [M_W-1:0] RECIP_M = M_W'((64'd1 << RECIP_SH) / 100);
	localparam int HUNDRED = 100;

	logic [SCALE_W-1:0]        scale_c;
	logic [GI_W:0]             num_a;
	logic [OROW_W:0]           num_b;
	logic [GI_W+SCALE_W:0]     full_a;
	logic [OROW_W+SCALE_W:0]   full_b;
	logic [GI_W+SCALE_W:0]     full_c;
	logic [N_W+M_W-1:0]        prod_a;
	logic [N_W+M_W-1:0]        prod_b;
	logic [N_W+M_W-1:0]        prod_c;
	logic [N_W-1:0]            back_a;
	logic [N_W-1:0]            back_b;
	logic [N_W-1:0]            back_c;
	logic [N_W-1:0]            rem_a;
	logic [N_W-1:0]            rem_b;
	logic [N_W-1:0]            rem_c;
	logic [Q_W-1:0]            fix_a;
	logic [Q_W-1:0]            fix_b;
	logic [Q_W-1:0]            fix_c;

	logic                      v_s1, v_s2, v_s3;
	logic [N_W-1:0]            pa_s1, pb_s1, pc_s1, pa_s2, pb_s2, pc_s2;
	logic [Q_W-1:0]            qa_s2, qb_s2, qc_s2;
	logic [END_W-1:0]          start_s3;
	logic [END_W-1:0]          end_s3;
	logic [LAST_W-1:0]         last_s3;

	// Clamp ratios below one to one
	assign scale_c = (scale < SCALE_MIN) ? SCALE_MIN : scale;

	// Numerators group * f, (group + 1) * f and (row + 1) * f
	assign num_a = {1'b0, grp} + (GI_W + 1)'(1);
	assign num_b = {1'b0, orow} + (OROW_W + 1)'(1);
	assign full_a = num_a * scale_c;
	assign full_b = num_b * scale_c;
	assign full_c = {1'b0, grp} * scale_c;

	// Reciprocal estimate of the quotient by one hundred, low by at most one
	assign prod_a = (N_W + M_W)'(pa_s1) * (N_W + M_W)'(RECIP_M);
	assign prod_b = (N_W + M_W)'(pb_s1) * (N_W + M_W)'(RECIP_M);
	assign prod_c = (N_W + M_W)'(pc_s1) * (N_W + M_W)'(RECIP_M);

	// Correct the estimate from the remainder
	assign back_a = N_W'({7'd0, qa_s2} * (Q_W + 7)'(HUNDRED));
	assign back_b = N_W'({7'd0, qb_s2} * (Q_W + 7)'(HUNDRED));
	assign back_c = N_W'({7'd0, qc_s2} * (Q_W + 7)'(HUNDRED));
	assign rem_a = pa_s2 - back_a;
	assign rem_b = pb_s2 - back_b;
	assign rem_c = pc_s2 - back_c;
	assign fix_a = (rem_a >= N_W'(HUNDRED)) ? qa_s2 + 1'b1 : qa_s2;
	assign fix_b = (rem_b >= N_W'(HUNDRED)) ? qb_s2 + 1'b1 : qb_s2;
	assign fix_c = (rem_c >= N_W'(HUNDRED)) ? qc_s2 + 1'b1 : qc_s2;

	// Advance stage flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= go;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage data
	always_ff @(posedge clk) begin
		pa_s1 <= N_W'(full_a);
		pb_s1 <= N_W'(full_b);
		pc_s1 <= N_W'(full_c);
		pa_s2 <= pa_s1;
		pb_s2 <= pb_s1;
		pc_s2 <= pc_s1;
		qa_s2 <= prod_a[RECIP_SH +: Q_W];
		qb_s2 <= prod_b[RECIP_SH +: Q_W];
		qc_s2 <= prod_c[RECIP_SH +: Q_W];
		start_s3 <= END_W'(fix_c);
		end_s3 <= END_W'(fix_a);
		last_s3 <= LAST_W'(fix_b - 1'b1);
	end

	assign done = v_s3;
	assign start_col = start_s3;
	assign end_col = end_s3;
	assign last_line = last_s3;

endmodule

>>> sv/bavg_div.sv
`timescale 1ns / 1ps

module bavg_div import bavg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  chan_vec_t        dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output chan_vec_t        quotient
);

	localparam int CNT_W = $clog2(CHAN_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W-1:0]  rem_q [CHAN_N];
	chan_vec_t         quo_q;
	logic [DVS_W:0]    part [CHAN_N];
	logic              ge [CHAN_N];

	// One restoring step per lane, divisor shared
	always_comb begin
		for (int c = 0; c < CHAN_N; c++) begin
			part[c] = {rem_q[c], quo_q[c][CHAN_W-1]};
			ge[c] = (part[c] >= {1'b0, dvs_q});
		end
	end

	// Count the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (go) begin
				cnt_q <= CNT_W'(CHAN_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Shift quotient bits in, keep partial remainders
	always_ff @(posedge clk) begin
		if (go) begin
			dvs_q <= divisor;
			quo_q <= dividend;
			for (int c = 0; c < CHAN_N; c++) begin
				rem_q[c] <= '0;
			end
		end else if (cnt_q != '0) begin
			for (int c = 0; c < CHAN_N; c++) begin
				rem_q[c] <= ge[c] ? DVS_W'(part[c] - {1'b0, dvs_q}) : part[c][DVS_W-1:0];
				quo_q[c] <= {quo_q[c][CHAN_W-2:0], ge[c]};
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

>>> sv/box_average_image_downscaler.sv
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// item      item_valid / item_stall   item (item_t)
// result    result_valid / result_stall result (result_t)
// config    scale_we                  scale_wdata
//
// A pixel inside a column group only adds to the running group sums. A pixel
// that closes a group reads the column store and writes it back; on an output
// row's last scanline it then runs the radix-2 divider and loads the output
// register. The boundary unit (two multiplies and a correction) then finds the
// next group. After reset, a frame start, a line end or a scale write the
// boundary unit runs before the next item. Reset needs no clearing pass: a fill
// count marks which columns hold sums. A stalled result holds the block only
// when a further result is ready to load.

module box_average_image_downscaler import bavg_pkg::*; #(
	parameter int OUT_WIDTH = OUT_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               scale_we,
	input  logic [SCALE_W-1:0] scale_wdata,
	input  logic               item_valid,
	output logic               item_stall,
	input  item_t              item,
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result
);

	localparam int GI_W = $clog2(OUT_WIDTH + 1);
	localparam int AW = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;
	localparam int END_W = $clog2(OUT_WIDTH * SCALE_MAX / 100 + 1);

	state_t               state_q, state_d;
	logic [SCALE_W-1:0]   scale_q;
	chan_vec_t            grp_sum_q;
	logic [SRC_COL_W-1:0] src_col_q;
	logic [GI_W-1:0]      grp_q;
	logic [OROW_W-1:0]    rows_q;
	logic [OROW_W-1:0]    orow_q;
	logic [GI_W-1:0]      fill_q;
	logic [END_W-1:0]     start_q;
	logic [END_W-1:0]     end_q;
	logic [LAST_W-1:0]    last_q;
	logic                 bounds_ok_q;
	logic                 redo_q;

	logic [GI_W-1:0]      grp_s1;
	chan_vec_t            sum_s1;
	logic                 last_s1;
	logic                 clear_s1;
	logic [PCNT_W-1:0]    pcnt_s1;
	logic [OROW_W-1:0]    rows_s1;
	logic [OROW_W-1:0]    orow_s1;

	logic                 result_valid_q;
	result_t              result_q;

	logic                 accept;
	logic                 is_pixel;
	logic                 in_range;
	logic                 complete;
	logic                 is_last;
	logic [SRC_COL_W-1:0] src_new;
	chan_vec_t            sum_new;
	logic [PCNT_W-1:0]    pcnt;

	logic                 bnd_go;
	logic                 bnd_done;
	logic [END_W-1:0]     bnd_start;
	logic [END_W-1:0]     bnd_end;
	logic [LAST_W-1:0]    bnd_last;

	logic                 ram_we;
	logic [ENTRY_W-1:0]   ram_rdata;
	chan_vec_t            rd_vec;
	chan_vec_t            acc;
	logic                 ent_ok;

	logic                 div_go;
	logic                 div_done;
	logic [OROW_W:0]      rows9;
	logic [DVS_W-1:0]     divisor;
	chan_vec_t            quo;
	logic                 load_out;

	// Decode the incoming pixel against the current group
	assign accept = item_valid && !item_stall;
	assign is_pixel = (item.kind == KIND_PIXEL);
	assign in_range = (grp_q < GI_W'(OUT_WIDTH));
	assign src_new = !in_range ? src_col_q :
		(src_col_q == SRC_COL_SAT) ? src_col_q : src_col_q + 1'b1;
	assign complete = in_range && (src_new >= SRC_COL_W'(end_q));
	assign is_last = (last_q == LAST_W'(item.scan_row));
	assign pcnt = PCNT_W'(end_q - start_q);

	always_comb begin
		sum_new[CH_R] = grp_sum_q[CH_R] + CHAN_W'(item.pixel_value[15:11]);
		sum_new[CH_G] = grp_sum_q[CH_G] + CHAN_W'(item.pixel_value[10:5]);
		sum_new[CH_B] = grp_sum_q[CH_B] + CHAN_W'(item.pixel_value[4:0]);
	end

	// Next state and strobes
	always_comb begin
		state_d = state_q;
		item_stall = 1'b1;
		bnd_go = 1'b0;
		ram_we = 1'b0;
		div_go = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!bounds_ok_q) begin
					bnd_go = 1'b1;
					state_d = ST_BOUNDS;
				end else begin
					item_stall = 1'b0;
					if (item_valid && is_pixel && complete) begin
						state_d = ST_ADD;
					end
				end
			end
			ST_BOUNDS: begin
				if (bnd_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_ADD: begin
				ram_we = 1'b1;
				if (last_s1) begin
					div_go = 1'b1;
					state_d = ST_DIV;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!result_valid_q || !result_stall) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Scale register and boundary validity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			bounds_ok_q <= 1'b0;
			redo_q <= 1'b0;
		end else begin
			if (scale_we) begin
				scale_q <= scale_wdata;
			end
			if (state_q == ST_BOUNDS && bnd_done) begin
				redo_q <= 1'b0;
			end else if (scale_we && (state_q == ST_BOUNDS || bnd_go)) begin
				redo_q <= 1'b1;
			end
			if (scale_we) begin
				bounds_ok_q <= 1'b0;
			end else if (state_q == ST_BOUNDS && bnd_done) begin
				bounds_ok_q <= !redo_q;
			end else if (accept && (!is_pixel || complete || item.line_end)) begin
				bounds_ok_q <= 1'b0;
			end
		end
	end

	// Latch group boundaries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q <= '0;
			last_q <= '0;
		end else if (state_q == ST_BOUNDS && bnd_done) begin
			start_q <= bnd_start;
			end_q <= bnd_end;
			last_q <= bnd_last;
		end
	end

	// Advance the raster position and running group sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_sum_q <= '0;
			src_col_q <= '0;
			grp_q <= '0;
			rows_q <= '0;
			orow_q <= '0;
		end else if (accept) begin
			if (!is_pixel) begin
				grp_sum_q <= '0;
				src_col_q <= '0;
				grp_q <= '0;
				rows_q <= '0;
				orow_q <= '0;
			end else begin
				if (in_range) begin
					src_col_q <= src_new;
					if (complete) begin
						grp_sum_q <= '0;
						grp_q <= grp_q + 1'b1;
					end else begin
						grp_sum_q <= sum_new;
					end
				end
				if (item.line_end) begin
					grp_sum_q <= '0;
					src_col_q <= '0;
					grp_q <= '0;
					if (is_last) begin
						rows_q <= '0;
						orow_q <= orow_q + 1'b1;
					end else begin
						rows_q <= rows_q + 1'b1;
					end
				end
			end
		end
	end

	// Track how many leading columns hold sums since the last clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept && !is_pixel) begin
			fill_q <= '0;
		end else if (accept && item.line_end && is_last && !complete) begin
			fill_q <= '0;
		end else if (ram_we) begin
			if (clear_s1) begin
				fill_q <= '0;
			end else if (grp_s1 >= fill_q) begin
				fill_q <= grp_s1 + 1'b1;
			end
		end
	end

	// Hold the closing group for the store and divider
	always_ff @(posedge clk) begin
		if (accept && is_pixel && complete) begin
			grp_s1 <= grp_q;
			sum_s1 <= sum_new;
			last_s1 <= is_last;
			clear_s1 <= item.line_end && is_last;
			pcnt_s1 <= pcnt;
			rows_s1 <= rows_q + 1'b1;
			orow_s1 <= orow_q;
		end
	end

	bavg_bounds #(
		.OUT_WIDTH(OUT_WIDTH)
	) u_bounds (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (bnd_go),
		.grp       (grp_q),
		.orow      (orow_q),
		.scale     (scale_q),
		.done      (bnd_done),
		.start_col (bnd_start),
		.end_col   (bnd_end),
		.last_line (bnd_last)
	);

	// Column store: read on accept, add and write back next cycle
	assign rd_vec = ram_rdata;
	assign ent_ok = (grp_s1 < fill_q);

	always_comb begin
		for (int c = 0; c < CHAN_N; c++) begin
			acc[c] = (ent_ok ? rd_vec[c] : '0) + sum_s1[c];
		end
	end

	bavg_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(OUT_WIDTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (grp_s1[AW-1:0]),
		.wdata (acc),
		.re    (accept),
		.raddr (grp_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Divisor: group pixels times rows, a zero row count meaning 256
	assign rows9 = (rows_s1 == '0) ? (OROW_W + 1)'(256) : {1'b0, rows_s1};
	assign divisor = DVS_W'(pcnt_s1) * DVS_W'(rows9);

	bavg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (acc),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quo)
	);

	// Output register: load when free or being taken, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q.out_pixel <= {quo[CH_R][4:0], 11'd0} | {3'd0, quo[CH_G][7:0], 5'd0} |
				{8'd0, quo[CH_B][7:0]};
			result_q.out_column <= COL_OUT_W'(grp_s1);
			result_q.out_row <= orow_s1;
			result_q.last_in_row <= (grp_s1 == GI_W'(OUT_WIDTH - 1));
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= GI_W'(OUT_WIDTH))
		else $error("column fill count beyond the store depth");

	a_bnd_done: assert property (@(posedge clk) disable iff (!arst_n)
		bnd_done |-> state_q == ST_BOUNDS)
		else $error("boundary result arrived outside the boundary wait");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide wait");

	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && result_valid && result_stall) |=>
		(state_q == ST_EMIT && $stable(result)))
		else $error("pending result overwrote a stalled one");

endmodule
